FILE: rtl/pmne_pkg.sv
// Shared types and constants for the pitch to note event block.
`timescale 1ns / 1ps

package pmne_pkg;

   localparam int NOTE_W = 27;                  // signed note value width
   localparam logic [25:0] NOTE_OFS = 26'd2858924; // 197*65536 - 12*log2(7040) in Q.16
   localparam logic [19:0] ATTACK_MAX = 20'hFFFFF;

   localparam logic [1:0] EV_NOTE_ON  = 2'd0;
   localparam logic [1:0] EV_NOTE_OFF = 2'd1;
   localparam logic [1:0] EV_BEND     = 2'd2;

   localparam logic [13:0] BEND_CENTER = 14'd8192;
   localparam logic [13:0] BEND_MAX    = 14'd8191;

   localparam logic REG_DEBOUNCE = 1'b0;
   localparam logic REG_BEND_RANGE = 1'b1;

   typedef enum logic [1:0] {
      MODE_SILENCE = 2'd0,
      MODE_ATTACK  = 2'd1,
      MODE_SUSTAIN = 2'd2,
      MODE_RELEASE = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOGF,
      ST_LOGS,
      ST_EVAL,
      ST_DIV,
      ST_EMIT
   } seq_state_type;

   typedef struct packed {
      logic        gate_open;
      logic [17:0] pitch_freq;
      logic [10:0] velocity_level;
      logic [15:0] block_samples;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  event_kind;
      logic [6:0]  note_number;
      logic [6:0]  note_velocity;
      logic [13:0] bend_value;
      logic        last_event;
   } rsp_word_type;

endpackage

FILE: rtl/pitch_to_midi_note_events_top.sv
// Top level: pitch to note event sequencer with shared log2 unit and divider.
`timescale 1ns / 1ps
//
// Takes one word per audio block on req_ (gate, pitch in 1/16 Hz, level,
// sample count) and returns zero to three event words on rsp_. The last
// word of a block carries last_event. A block that causes no event gives
// no rsp_ word.
// req_stall is low only while the sequencer is idle; a word is taken when
// req_valid is high and req_stall low. Silence and release use neither the
// log2 unit nor the divider; the log2 unit is used once per pitch in sustain
// and up to twice in attack, and a pitch bend adds a restoring division.
// Results leave through one output register; while rsp_stall is high the
// sequencer holds the pending events and the output word stays put. The
// last word of a block may still wait while the next req_ word is taken.
// csr_ writes (index 0 debounce samples, 1 bend range) are always ready and
// are meant to be issued while the block is idle.
// Reset (synchronous, high) returns to silence, no note playing, debounce
// 480 and bend range 2.
//
module pitch_to_midi_note_events_top
   import pmne_pkg::*;
#(
   parameter int NOTE_FRAC_BITS = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [15:0]  csr_wdata
);

   localparam int DW = NOTE_FRAC_BITS + 19;   // divider width
   localparam int MW = NOTE_FRAC_BITS + 1;    // bend drift magnitude width

   seq_state_type state_ff, state_in;
   mode_type      mode_ff, mode_in;
   logic [19:0]   attack_count_ff, attack_count_in;
   logic [17:0]   stable_freq_ff, stable_freq_in;
   logic [6:0]    playing_note_ff, playing_note_in;
   logic          note_active_ff, note_active_in;
   logic [15:0]   debounce_ff;
   logic [5:0]    bend_range_ff;
   logic [17:0]   freq_ff, freq_in;
   logic [10:0]   level_ff, level_in;
   logic signed [NOTE_W-1:0] nf_ff, nf_in;
   logic signed [NOTE_W-1:0] ns_ff, ns_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] dsh_ff, dsh_in;
   logic [13:0]   quo_ff, quo_in;
   logic          neg_ff, neg_in;
   logic [3:0]    step_ff, step_in;
   rsp_word_type  ev_ff [3];
   rsp_word_type  ev_in [3];
   logic [1:0]    ev_cnt_ff, ev_cnt_in;
   logic [1:0]    ev_idx_ff, ev_idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_word_ff, rsp_word_in;

   logic                     nu_run;
   logic [17:0]              nu_freq;
   logic                     nu_done;
   logic signed [NOTE_W-1:0] nu_note;

   pmne_note_unit #(
      .NOTE_FRAC_BITS(NOTE_FRAC_BITS)
   ) u_note (
      .clock(clock),
      .reset(reset),
      .run  (nu_run),
      .freq (nu_freq),
      .done (nu_done),
      .note (nu_note)
   );

   function automatic rsp_word_type make_ev(logic [1:0] kind, logic [6:0] nn,
                                            logic [6:0] vel, logic [13:0] bend);
      rsp_word_type e;
      e.event_kind    = kind;
      e.note_number   = nn;
      e.note_velocity = vel;
      e.bend_value    = bend;
      e.last_event    = 1'b0;
      return e;
   endfunction

   function automatic logic [6:0] round_note(logic signed [NOTE_W-1:0] n);
      logic signed [NOTE_W:0] w;
      logic signed [NOTE_W:0] r;
      w = $signed({n[NOTE_W-1], n}) + $signed((NOTE_W + 1)'(128 << NOTE_FRAC_BITS))
          + $signed((NOTE_W + 1)'(1 << (NOTE_FRAC_BITS - 1)));
      r = (w >>> NOTE_FRAC_BITS) - $signed((NOTE_W + 1)'(128));
      if (r < 0) begin
         return 7'd0;
      end else if (r > $signed((NOTE_W + 1)'(127))) begin
         return 7'd127;
      end
      return r[6:0];
   endfunction

   function automatic logic [6:0] velocity_of(logic [10:0] lvl);
      logic [17:0] t;
      t = (18'(lvl) << 7) - 18'(lvl);
      if (t[17:10] == 8'd0) begin
         return 7'd1;
      end else if (t[17:10] > 8'd127) begin
         return 7'd127;
      end
      return t[16:10];
   endfunction

   // drift and bend offsets
   logic signed [NOTE_W:0] pn_fx;
   logic signed [NOTE_W:0] diff_as;     // attack: freq vs stable
   logic signed [NOTE_W:0] diff_sp;     // sustain: freq vs playing note
   logic [NOTE_W:0]        abs_as;
   logic [NOTE_W:0]        abs_sp;
   logic [NOTE_W:0]        one_semi;

   assign pn_fx    = $signed((NOTE_W + 1)'(playing_note_ff) << NOTE_FRAC_BITS);
   assign diff_as  = $signed({nf_ff[NOTE_W-1], nf_ff}) - $signed({ns_ff[NOTE_W-1], ns_ff});
   assign diff_sp  = $signed({nf_ff[NOTE_W-1], nf_ff}) - pn_fx;
   assign abs_as   = diff_as < 0 ? (NOTE_W + 1)'(-diff_as) : (NOTE_W + 1)'(diff_as);
   assign abs_sp   = diff_sp < 0 ? (NOTE_W + 1)'(-diff_sp) : (NOTE_W + 1)'(diff_sp);
   assign one_semi = (NOTE_W + 1)'(1 << NOTE_FRAC_BITS);

   always_comb begin
      mode_type    m1;
      logic [19:0] ac1;
      logic [17:0] sf1;
      logic [20:0] ac_sum;
      logic        drift;
      logic [19:0] ac2;
      logic [6:0]  rn;
      logic [MW-1:0] mag;
      logic [5:0]  r_eff;
      logic        ge;
      logic [13:0] q;

      state_in        = state_ff;
      mode_in         = mode_ff;
      attack_count_in = attack_count_ff;
      stable_freq_in  = stable_freq_ff;
      playing_note_in = playing_note_ff;
      note_active_in  = note_active_ff;
      freq_in         = freq_ff;
      level_in        = level_ff;
      nf_in           = nf_ff;
      ns_in           = ns_ff;
      rem_in          = rem_ff;
      dsh_in          = dsh_ff;
      quo_in          = quo_ff;
      neg_in          = neg_ff;
      step_in         = step_ff;
      ev_in           = ev_ff;
      ev_cnt_in       = ev_cnt_ff;
      ev_idx_in       = ev_idx_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_word_in     = rsp_word_ff;
      nu_run          = 1'b0;
      nu_freq         = freq_ff;
      m1     = mode_ff;
      ac1    = attack_count_ff;
      sf1    = stable_freq_ff;
      ac_sum = 21'd0;
      drift  = 1'b0;
      ac2    = attack_count_ff;
      rn     = 7'd0;
      mag    = abs_sp[MW-1:0];
      r_eff  = (bend_range_ff == 6'd0) ? 6'd1 : bend_range_ff;
      ge     = ({1'b0, rem_ff} >= {1'b0, dsh_ff});
      q      = {quo_ff[12:0], ge};

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               freq_in   = req_word.pitch_freq;
               level_in  = req_word.velocity_level;
               ev_cnt_in = 2'd0;
               ev_idx_in = 2'd0;
               if (!req_word.gate_open) begin
                  if (mode_ff == MODE_ATTACK || mode_ff == MODE_SUSTAIN) begin
                     m1 = MODE_RELEASE;
                  end
               end else if (mode_ff == MODE_SILENCE || mode_ff == MODE_RELEASE) begin
                  m1  = MODE_ATTACK;
                  ac1 = 20'd0;
                  sf1 = req_word.pitch_freq;
               end
               mode_in        = m1;
               stable_freq_in = sf1;
               state_in       = ST_EMIT;
               case (m1)
                  MODE_ATTACK: begin
                     ac_sum = {1'b0, ac1} + 21'(req_word.block_samples);
                     attack_count_in = ac_sum[20] ? ATTACK_MAX : ac_sum[19:0];
                     if (req_word.pitch_freq != 18'd0) begin
                        state_in = ST_LOGF;
                     end
                  end
                  MODE_SUSTAIN: begin
                     if (req_word.pitch_freq != 18'd0) begin
                        state_in = ST_LOGF;
                     end
                  end
                  MODE_RELEASE: begin
                     mode_in = MODE_SILENCE;
                     if (note_active_ff) begin
                        ev_in[0] = make_ev(EV_NOTE_OFF, playing_note_ff, 7'd0, BEND_CENTER);
                        ev_in[1] = make_ev(EV_BEND, 7'd0, 7'd0, BEND_CENTER);
                        ev_cnt_in       = 2'd2;
                        note_active_in  = 1'b0;
                        playing_note_in = 7'd0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOGF: begin
            nu_run  = 1'b1;
            nu_freq = freq_ff;
            if (nu_done) begin
               nf_in = nu_note;
               if (mode_ff == MODE_ATTACK && stable_freq_ff != 18'd0) begin
                  state_in = ST_LOGS;
               end else begin
                  state_in = ST_EVAL;
               end
            end
         end
         ST_LOGS: begin
            nu_run  = 1'b1;
            nu_freq = stable_freq_ff;
            if (nu_done) begin
               ns_in    = nu_note;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_EMIT;
            if (mode_ff == MODE_ATTACK) begin
               drift = (stable_freq_ff == 18'd0) || (abs_as > one_semi);
               ac2   = drift ? 20'd0 : attack_count_ff;
               if (drift) begin
                  stable_freq_in  = freq_ff;
                  attack_count_in = 20'd0;
               end
               if (ac2 >= 20'(debounce_ff)) begin
                  rn              = round_note(drift ? nf_ff : ns_ff);
                  mode_in         = MODE_SUSTAIN;
                  playing_note_in = rn;
                  note_active_in  = 1'b1;
                  ev_in[0]  = make_ev(EV_NOTE_ON, rn, velocity_of(level_ff), BEND_CENTER);
                  ev_cnt_in = 2'd1;
               end
            end else if (mode_ff == MODE_SUSTAIN) begin
               if (abs_sp > one_semi) begin
                  rn = round_note(nf_ff);
                  ev_in[0] = make_ev(EV_NOTE_OFF, playing_note_ff, 7'd0, BEND_CENTER);
                  ev_in[1] = make_ev(EV_NOTE_ON, rn, velocity_of(level_ff), BEND_CENTER);
                  ev_in[2] = make_ev(EV_BEND, 7'd0, 7'd0, BEND_CENTER);
                  ev_cnt_in       = 2'd3;
                  playing_note_in = rn;
                  note_active_in  = 1'b1;
               end else begin
                  // |drift| * 8191 / (range << frac), one quotient bit a cycle
                  rem_in   = (DW'(mag) << 13) - DW'(mag);
                  dsh_in   = DW'(r_eff) << (NOTE_FRAC_BITS + 13);
                  neg_in   = diff_sp < 0;
                  quo_in   = 14'd0;
                  step_in  = 4'd0;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            rem_in  = ge ? rem_ff - dsh_ff : rem_ff;
            dsh_in  = dsh_ff >> 1;
            quo_in  = q;
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd13) begin
               if (q > BEND_MAX) begin
                  q = BEND_MAX;
               end
               ev_in[0]  = make_ev(EV_BEND, 7'd0, 7'd0,
                                   neg_ff ? BEND_CENTER - q : BEND_CENTER + q);
               ev_cnt_in = 2'd1;
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (ev_idx_ff == ev_cnt_ff) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || !rsp_stall) begin
               rsp_word_in            = ev_ff[ev_idx_ff];
               rsp_word_in.last_event = (ev_idx_ff == ev_cnt_ff - 2'd1);
               rsp_valid_in           = 1'b1;
               ev_idx_in              = ev_idx_ff + 2'd1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         mode_ff         <= MODE_SILENCE;
         attack_count_ff <= 20'd0;
         stable_freq_ff  <= 18'd0;
         playing_note_ff <= 7'd0;
         note_active_ff  <= 1'b0;
         ev_cnt_ff       <= 2'd0;
         ev_idx_ff       <= 2'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         mode_ff         <= mode_in;
         attack_count_ff <= attack_count_in;
         stable_freq_ff  <= stable_freq_in;
         playing_note_ff <= playing_note_in;
         note_active_ff  <= note_active_in;
         ev_cnt_ff       <= ev_cnt_in;
         ev_idx_ff       <= ev_idx_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      freq_ff     <= freq_in;
      level_ff    <= level_in;
      nf_ff       <= nf_in;
      ns_ff       <= ns_in;
      rem_ff      <= rem_in;
      dsh_ff      <= dsh_in;
      quo_ff      <= quo_in;
      neg_ff      <= neg_in;
      step_ff     <= step_in;
      ev_ff       <= ev_in;
      rsp_word_ff <= rsp_word_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= 16'd480;
         bend_range_ff <= 6'd2;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_DEBOUNCE:   debounce_ff   <= csr_wdata;
            REG_BEND_RANGE: bend_range_ff <= csr_wdata[5:0];
            default: begin
            end
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // no note sounding means the playing note is cleared
   a_note_clear: assert property (@(posedge clock) disable iff (reset)
      !note_active_ff |-> (playing_note_ff == 7'd0))
      else $error("playing note set without an active note");

   // release is resolved within the block that enters it
   a_release_short: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (mode_ff != MODE_RELEASE))
      else $error("release mode persisted past its block");

   // the divider only runs for a bend in sustain
   a_div_sustain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (mode_ff == MODE_SUSTAIN && note_active_ff))
      else $error("divider running outside sustain");

endmodule

FILE: rtl/pmne_note_unit.sv
// Iterative log2 by repeated squaring, giving the fixed-point note value.
`timescale 1ns / 1ps

module pmne_note_unit
   import pmne_pkg::*;
#(
   parameter int NOTE_FRAC_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     run,
   input  logic [17:0]              freq,
   output logic                     done,
   output logic signed [NOTE_W-1:0] note
);

   localparam int SH = 16 - NOTE_FRAC_BITS;

   logic        busy_ff, busy_in;
   logic [4:0]  step_ff, step_in;
   logic [4:0]  exp_ff, exp_in;
   logic [15:0] frac_ff, frac_in;
   logic [30:0] x_ff, x_in;

   logic [4:0]  lead;
   logic [63:0] sq;
   logic [31:0] sq_sh;
   logic [20:0] lg;
   logic [25:0] u;
   logic [25:0] w;

   always_comb begin
      lead = 5'd0;
      for (int i = 0; i < 18; i++) begin
         if (freq[i]) begin
            lead = 5'(i);
         end
      end
   end

   assign sq    = 64'(x_ff) * 64'(x_ff);
   assign sq_sh = sq[61:30];

   assign lg   = {exp_ff, frac_ff};
   assign u    = (26'(lg) << 3) + (26'(lg) << 2) + NOTE_OFS;
   assign w    = (u + 26'(1 << (SH - 1))) >> SH;
   assign note = $signed(NOTE_W'(w)) - $signed(NOTE_W'(128 << NOTE_FRAC_BITS));
   assign done = busy_ff && (step_ff == 5'd16);

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      exp_in  = exp_ff;
      frac_in = frac_ff;
      x_in    = x_ff;
      if (!busy_ff) begin
         if (run) begin
            busy_in = 1'b1;
            step_in = 5'd0;
            exp_in  = lead;
            frac_in = 16'd0;
            x_in    = 31'(freq) << (5'd30 - lead);
         end
      end else if (step_ff == 5'd16) begin
         busy_in = 1'b0;
      end else begin
         step_in = step_ff + 5'd1;
         frac_in = {frac_ff[14:0], sq_sh[31]};
         x_in    = sq_sh[31] ? sq_sh[31:1] : sq_sh[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      exp_ff  <= exp_in;
      frac_ff <= frac_in;
      x_ff    <= x_in;
   end

endmodule

FILE: verif/pitch_to_midi_note_events_top_tb.sv
// Self-checking testbench for the pitch to note event block.
`timescale 1ns / 1ps

module pitch_to_midi_note_events_top_tb;
   import pmne_pkg::*;

   localparam int FRAC = 8;
   localparam int IDLE_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = 1'b0;
   logic [15:0] csr_wdata = '0;

   pitch_to_midi_note_events_top #(.NOTE_FRAC_BITS(FRAC)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   req_word_type block_queue[$];
   rsp_word_type events_due[$];
   int mismatches = 0;
   int events_seen = 0;
   int idle_cycles = 0;

   // note tracker state and register copies
   mode_type    trk_mode = MODE_SILENCE;
   logic [19:0] trk_count = '0;
   logic [17:0] trk_stable = '0;
   logic [6:0]  trk_note = '0;
   logic        trk_active = 1'b0;
   logic [15:0] cfg_debounce = 16'd480;
   logic [5:0]  cfg_range = 6'd2;

   function automatic longint pitch_log2_q16(longint unsigned f);
      int e;
      longint unsigned x;
      longint unsigned frac;
      e = 17;
      frac = 0;
      while (e > 0 && f[e] == 1'b0) e--;
      x = f << (30 - e);
      for (int i = 0; i < 16; i++) begin
         x = (x * x) >> 30;
         frac = frac << 1;
         if (x >= (64'd1 << 31)) begin
            frac = frac | 1;
            x = x >> 1;
         end
      end
      return (longint'(e) << 16) | longint'(frac);
   endfunction

   // semitone value in 1/256 semitone, rounded half up
   function automatic longint note_fixed(logic [17:0] f);
      longint u;
      if (f == 0) return 0;
      u = pitch_log2_q16(f) * 12 - 64'sd12 * 837639 + 64'sd197 * 65536;
      return ((u + (64'sd1 << (15 - FRAC))) >>> (16 - FRAC)) - (64'sd128 << FRAC);
   endfunction

   function automatic logic [6:0] note_round(longint n);
      longint v;
      longint r;
      v = n + (64'sd128 << FRAC) + (64'sd1 << (FRAC - 1));
      if (v < 0) return 7'd0;
      r = (v >>> FRAC) - 128;
      if (r < 0) return 7'd0;
      if (r > 127) return 7'd127;
      return r[6:0];
   endfunction

   function automatic logic [6:0] vel_scale(logic [10:0] lvl);
      int v;
      v = (int'(lvl) * 127) >> 10;
      if (v < 1) v = 1;
      if (v > 127) v = 127;
      return v[6:0];
   endfunction

   function automatic longint abs_l(longint a);
      return a < 0 ? -a : a;
   endfunction

   function automatic rsp_word_type mk_event(logic [1:0] k, logic [6:0] nt, logic [6:0] vl,
                                            logic [13:0] bd);
      rsp_word_type w;
      w.event_kind = k;
      w.note_number = nt;
      w.note_velocity = vl;
      w.bend_value = bd;
      w.last_event = 1'b0;
      return w;
   endfunction

   // advance the tracker by one block and queue the events it causes
   task automatic block_events(req_word_type w);
      rsp_word_type ev[$];
      int acc;
      longint ex, diff, den, q;
      if (!w.gate_open) begin
         if (trk_mode == MODE_ATTACK || trk_mode == MODE_SUSTAIN) trk_mode = MODE_RELEASE;
      end else if (trk_mode == MODE_SILENCE || trk_mode == MODE_RELEASE) begin
         trk_mode = MODE_ATTACK;
         trk_count = '0;
         trk_stable = w.pitch_freq;
      end
      case (trk_mode)
         MODE_ATTACK: begin
            acc = int'(trk_count) + int'(w.block_samples);
            trk_count = (acc > int'(ATTACK_MAX)) ? ATTACK_MAX : acc[19:0];
            if (w.pitch_freq != 0) begin
               if (trk_stable == 0 ||
                   abs_l(note_fixed(w.pitch_freq) - note_fixed(trk_stable)) > (64'sd1 << FRAC)) begin
                  trk_stable = w.pitch_freq;
                  trk_count = '0;
               end
               if (trk_count >= cfg_debounce) begin
                  trk_mode = MODE_SUSTAIN;
                  trk_note = note_round(note_fixed(trk_stable));
                  trk_active = 1'b1;
                  ev.push_back(mk_event(EV_NOTE_ON, trk_note, vel_scale(w.velocity_level),
                                        BEND_CENTER));
               end
            end
         end
         MODE_SUSTAIN: begin
            if (w.pitch_freq != 0) begin
               ex = note_fixed(w.pitch_freq);
               diff = ex - (longint'(trk_note) << FRAC);
               if (abs_l(diff) > (64'sd1 << FRAC)) begin
                  ev.push_back(mk_event(EV_NOTE_OFF, trk_note, 7'd0, BEND_CENTER));
                  trk_note = note_round(ex);
                  trk_active = 1'b1;
                  ev.push_back(mk_event(EV_NOTE_ON, trk_note, vel_scale(w.velocity_level),
                                        BEND_CENTER));
                  ev.push_back(mk_event(EV_BEND, 7'd0, 7'd0, BEND_CENTER));
               end else begin
                  den = longint'((cfg_range == 0) ? 6'd1 : cfg_range) << FRAC;
                  q = (diff * 8191) / den;
                  if (q > 8191) q = 8191;
                  if (q < -8191) q = -8191;
                  q = q + 8192;
                  ev.push_back(mk_event(EV_BEND, 7'd0, 7'd0, q[13:0]));
               end
            end
         end
         MODE_RELEASE: begin
            if (trk_active) begin
               ev.push_back(mk_event(EV_NOTE_OFF, trk_note, 7'd0, BEND_CENTER));
               trk_active = 1'b0;
               trk_note = '0;
               ev.push_back(mk_event(EV_BEND, 7'd0, 7'd0, BEND_CENTER));
            end
            trk_mode = MODE_SILENCE;
         end
         default: ;
      endcase
      if (ev.size() > 0) ev[ev.size() - 1].last_event = 1'b1;
      foreach (ev[i]) events_due.push_back(ev[i]);
   endtask

   // mostly short gaps, a few long ones
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // driver
   always @(posedge clock) begin : drive
      int gap_left;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) block_events(req_word);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0 || block_queue.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_valid <= 1'b0;
            end else begin
               req_word <= block_queue.pop_front();
               req_valid <= 1'b1;
               gap_left = gap_len();
            end
         end
      end
   end

   task automatic report(string what, rsp_word_type e, rsp_word_type a);
      mismatches++;
      if (mismatches <= 10)
         $display("ERROR %s: exp kind=%0d note=%0d vel=%0d bend=%0d last=%0d, got kind=%0d note=%0d vel=%0d bend=%0d last=%0d",
                  what, e.event_kind, e.note_number, e.note_velocity, e.bend_value,
                  e.last_event, a.event_kind, a.note_number, a.note_velocity,
                  a.bend_value, a.last_event);
   endtask

   // monitor and receiver stall
   always @(posedge clock) begin : watch
      rsp_word_type e;
      int hold_left;
      bit held;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
         held = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            events_seen++;
            if (events_due.size() == 0) begin
               report("unexpected word", '0, rsp_word);
            end else begin
               e = events_due.pop_front();
               if (rsp_word.event_kind != e.event_kind || rsp_word.note_number != e.note_number ||
                   rsp_word.note_velocity != e.note_velocity ||
                   rsp_word.bend_value != e.bend_value || rsp_word.last_event != e.last_event)
                  report("word mismatch", e, rsp_word);
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!held && events_seen >= 40) begin
            // long hold-off so the block backs up into its input
            held = 1'b1;
            hold_left = 300;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= (gap_len() > 0);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic csr_write(logic idx, logic [15:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == REG_DEBOUNCE) cfg_debounce = data;
      else cfg_range = data[5:0];
      csr_valid <= 1'b0;
   endtask

   task automatic add_block(bit g, int f, int lvl, int blk);
      req_word_type w;
      w.gate_open = g;
      w.pitch_freq = f[17:0];
      w.velocity_level = lvl[10:0];
      w.block_samples = blk[15:0];
      block_queue.push_back(w);
   endtask

   function automatic int pick_blk();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return $urandom_range(16, 1024);
      if (r < 9) return $urandom_range(1024, 65535);
      return (r[0]) ? 65535 : 0;
   endfunction

   // gate-open runs around a base pitch, with jumps, dropouts and noise
   task automatic add_random(int count);
      int base, f, n, len;
      n = 0;
      while (n < count) begin
         if ($urandom_range(0, 99) < 15) begin
            add_block($urandom_range(0, 1), $urandom_range(0, 262143), $urandom_range(0, 2047),
                      $urandom_range(0, 65535));
            n++;
         end else begin
            base = $urandom_range(300, 250000);
            len = $urandom_range(3, 20);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(0, 9) == 0)
                  base = ($urandom_range(0, 1)) ? base * $urandom_range(110, 150) / 100
                                               : base * $urandom_range(60, 90) / 100;
               if (base < 1) base = 1;
               if (base > 262143) base = 262143;
               f = base * (1000 + $urandom_range(0, 80) - 40) / 1000;
               if (f > 262143) f = 262143;
               if ($urandom_range(0, 19) == 0) f = 0;
               add_block(1'b1, f, $urandom_range(0, 2047), pick_blk());
            end
            add_block(1'b0, $urandom_range(0, 262143), $urandom_range(0, 2047), pick_blk());
            n += len + 1;
         end
      end
   endtask

   task automatic drain();
      while (block_queue.size() != 0 || req_valid || events_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: zero bend range, immediate note-on, extremes
      csr_write(REG_DEBOUNCE, 16'd0);
      csr_write(REG_BEND_RANGE, 16'd0);
      add_block(1'b0, 0, 0, 0);              // silence stays silent
      add_block(1'b1, 0, 1024, 100);         // no pitch in attack
      add_block(1'b1, 7040, 2047, 0);        // zero stable pitch counts as drift
      add_block(1'b1, 7100, 500, 10);        // small bend
      add_block(1'b1, 6980, 500, 10);
      add_block(1'b1, 0, 500, 10);           // no pitch in sustain
      add_block(1'b1, 262143, 2047, 65535);  // jump up
      add_block(1'b1, 1, 0, 1);              // jump down, minimum velocity
      add_block(1'b0, 1, 0, 0);              // release with note
      add_block(1'b0, 262143, 2047, 65535);
      drain();

      csr_write(REG_DEBOUNCE, 16'd65535);
      csr_write(REG_BEND_RANGE, 16'd48);
      for (int i = 0; i < 17; i++) add_block(1'b1, 0, 300, 65535); // count saturates
      add_block(1'b1, 7040, 300, 65535);
      add_block(1'b1, 7040, 300, 65535);
      add_block(1'b0, 7040, 300, 0);         // release with note
      add_random(70);
      drain();

      csr_write(REG_DEBOUNCE, 16'd480);
      csr_write(REG_BEND_RANGE, 16'd2);
      add_random(70);
      drain();

      csr_write(REG_DEBOUNCE, 16'd0);
      csr_write(REG_BEND_RANGE, 16'd1);
      add_random(70);
      drain();

      csr_write(REG_DEBOUNCE, 16'd200);
      csr_write(REG_BEND_RANGE, 16'd12);
      add_random(70);
      drain();

      csr_write(REG_DEBOUNCE, 16'($urandom_range(0, 2000)));
      csr_write(REG_BEND_RANGE, 16'($urandom_range(0, 63)));
      add_random(80);
      drain();

      if (mismatches == 0 && events_due.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/pmne_pkg.sv
rtl/pmne_note_unit.sv
rtl/pitch_to_midi_note_events_top.sv
verif/pitch_to_midi_note_events_top_tb.sv
